/* rtl/core/srsw_pkg.sv */
`timescale 1ns / 1ps

package srsw_pkg;

  localparam int CMD_W   = 2;
  localparam int SEQ_W   = 4;
  localparam int ATT_W   = 4;
  localparam int PEND_W  = 5;
  localparam int KIND_W  = 3;
  localparam int TIMER_W = 16;
  localparam int WIN_W   = 4;
  localparam int RETRY_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_GENERATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED,
    KIND_SENT,
    KIND_RESENT,
    KIND_ACK_TAKEN,
    KIND_ACK_IGNORED,
    KIND_FULL,
    KIND_GIVE_UP,
    KIND_IDLE
  } kind_t;

  // effective (clamped) configuration
  typedef struct packed {
    logic [WIN_W-1:0]   window;
    logic [PEND_W-1:0]  buffer;
    logic [TIMER_W-1:0] timeout;
    logic [RETRY_W-1:0] retry;
  } cfg_eff_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_GEN_FULL,
    OP_GEN_ADMIT,
    OP_SEND,
    OP_ACK_READ,
    OP_ACK_TAKE,
    OP_ACK_IGNORE,
    OP_SLIDE_READ,
    OP_SLIDE_CLEAR,
    OP_SCAN_READ,
    OP_SCAN_SKIP,
    OP_SCAN_DEC,
    OP_SCAN_RESEND,
    OP_SCAN_ABORT,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic emit_ok;
    logic out_free;
    logic aborted;
    logic full;
    logic send_ok;
    logic ack_ok;
    logic slide_ok;
    logic rd_mark;
    logic scan_done;
    logic timer_gt1;
    logic at_limit;
  } dp_status_t;

endpackage

/* rtl/core/srsw_datapath.sv */
`timescale 1ns / 1ps

module srsw_datapath import srsw_pkg::*; #(
  parameter int SEQ_COUNT = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  cfg_eff_t            cfg,
  input  logic [SEQ_W-1:0]    ack_seq,
  output dp_status_t          status,
  output logic                out_valid,
  input  logic                out_ready,
  output kind_t               out_kind,
  output logic [SEQ_W-1:0]    out_seq,
  output logic [ATT_W-1:0]    out_attempt,
  output logic [PEND_W-1:0]   out_outstanding,
  output logic                out_last
);

  localparam int SW = $clog2(SEQ_COUNT);
  localparam int CW = $clog2(SEQ_COUNT + 1);

  typedef struct packed {
    logic               mark;
    logic [ATT_W-1:0]   tries;
    logic [TIMER_W-1:0] timer;
  } slot_t;

  // (a - b) mod SEQ_COUNT
  function automatic logic [SW-1:0] ring_dist(input logic [SW-1:0] a,
                                              input logic [SW-1:0] b);
    logic [SW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + (SW+1)'(SEQ_COUNT);
    end
    return d[SW-1:0];
  endfunction

  function automatic logic [SW-1:0] inc(input logic [SW-1:0] a);
    return (a == SW'(SEQ_COUNT - 1)) ? '0 : a + 1'b1;
  endfunction

  // ack number modulo SEQ_COUNT; at most three subtractions for SEQ_COUNT >= 4
  function automatic logic [SW-1:0] slot_of(input logic [SEQ_W-1:0] a);
    logic [8:0] v;
    v = 9'(a);
    for (int k = 0; k < 4; k++) begin
      if (v >= 9'(SEQ_COUNT)) begin
        v = v - 9'(SEQ_COUNT);
      end
    end
    return v[SW-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] to_seq(input logic [SW-1:0] s);
    logic [SW+SEQ_W-1:0] t;
    t = {{SEQ_W{1'b0}}, s};
    return t[SEQ_W-1:0];
  endfunction

  slot_t mem [SEQ_COUNT];
  slot_t rd_data;

  logic [SW-1:0]     next_new, base, nts, ack_slot, scan_ptr;
  logic [SW-1:0]     next_new_next, base_next, nts_next;
  logic [PEND_W-1:0] pending, pending_next;
  logic              aborted, aborted_next;
  logic [CW-1:0]     scan_rem;

  logic              held_v;
  kind_t             held_kind;
  logic [SEQ_W-1:0]  held_seq;
  logic [ATT_W-1:0]  held_att;
  logic [PEND_W-1:0] held_outst;

  logic              wr_en, rd_en;
  logic [SW-1:0]     wr_addr, rd_addr;
  slot_t             wr_data;
  logic              emit, finish, latch, scan_step;
  kind_t             e_kind;
  logic [SEQ_W-1:0]  e_seq;
  logic [ATT_W-1:0]  e_att;

  logic [SW-1:0]     off_new;
  logic [CW-1:0]     adm_span, sent_span;
  logic              out_free, load_out;

  assign off_new   = ring_dist(next_new, base);
  assign adm_span  = (off_new == '0 && pending != '0) ? CW'(SEQ_COUNT) : CW'(off_new);
  assign sent_span = (nts == next_new) ? adm_span : CW'(ring_dist(nts, base));

  assign out_free = !out_valid || out_ready;
  assign load_out = (emit && held_v) || finish;

  always_comb begin
    status.emit_ok   = !held_v || out_free;
    status.out_free  = out_free;
    status.aborted   = aborted;
    status.full      = (pending >= cfg.buffer) || (next_new == base && pending != '0);
    status.send_ok   = (nts != next_new) &&
                       ((SW+WIN_W)'(ring_dist(nts, base)) < (SW+WIN_W)'(cfg.window));
    status.ack_ok    = (CW'(ring_dist(ack_slot, base)) < sent_span) && !rd_data.mark;
    status.slide_ok  = (base != nts);
    status.rd_mark   = rd_data.mark;
    status.scan_done = (scan_rem == '0);
    status.timer_gt1 = (rd_data.timer > TIMER_W'(1));
    status.at_limit  = (rd_data.tries >= cfg.retry);
  end

  always_comb begin
    next_new_next = next_new;
    base_next     = base;
    nts_next      = nts;
    pending_next  = pending;
    aborted_next  = aborted;
    wr_en         = 1'b0;
    wr_addr       = next_new;
    wr_data       = '0;
    rd_en         = 1'b0;
    rd_addr       = ack_slot;
    emit          = 1'b0;
    finish        = 1'b0;
    latch         = 1'b0;
    scan_step     = 1'b0;
    e_kind        = KIND_IDLE;
    e_seq         = '0;
    e_att         = '0;
    unique case (op)
      OP_NONE: begin
      end
      OP_LATCH: begin
        latch = 1'b1;
      end
      OP_GEN_FULL: begin
        emit   = 1'b1;
        e_kind = KIND_FULL;
        e_seq  = to_seq(next_new);
      end
      OP_GEN_ADMIT: begin
        wr_en         = 1'b1;
        wr_addr       = next_new;
        next_new_next = inc(next_new);
        pending_next  = pending + 1'b1;
        emit          = 1'b1;
        e_kind        = KIND_QUEUED;
        e_seq         = to_seq(next_new);
      end
      OP_SEND: begin
        // a slot is sent for the first time once, so tries goes 0 -> 1
        wr_en         = 1'b1;
        wr_addr       = nts;
        wr_data.tries = ATT_W'(1);
        wr_data.timer = cfg.timeout;
        nts_next      = inc(nts);
        emit          = 1'b1;
        e_kind        = KIND_SENT;
        e_seq         = to_seq(nts);
        e_att         = ATT_W'(1);
      end
      OP_ACK_READ: begin
        rd_en   = 1'b1;
        rd_addr = ack_slot;
      end
      OP_ACK_TAKE: begin
        wr_en         = 1'b1;
        wr_addr       = ack_slot;
        wr_data.mark  = 1'b1;
        wr_data.tries = rd_data.tries;
        pending_next  = pending - 1'b1;
        emit          = 1'b1;
        e_kind        = KIND_ACK_TAKEN;
        e_seq         = to_seq(ack_slot);
        e_att         = rd_data.tries;
      end
      OP_ACK_IGNORE: begin
        emit   = 1'b1;
        e_kind = KIND_ACK_IGNORED;
        e_seq  = to_seq(ack_slot);
      end
      OP_SLIDE_READ: begin
        rd_en   = 1'b1;
        rd_addr = base;
      end
      OP_SLIDE_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = base;
        base_next = inc(base);
      end
      OP_SCAN_READ: begin
        rd_en   = 1'b1;
        rd_addr = scan_ptr;
      end
      OP_SCAN_SKIP: begin
        scan_step = 1'b1;
      end
      OP_SCAN_DEC: begin
        wr_en         = 1'b1;
        wr_addr       = scan_ptr;
        wr_data.tries = rd_data.tries;
        wr_data.timer = rd_data.timer - 1'b1;
        scan_step     = 1'b1;
      end
      OP_SCAN_RESEND: begin
        wr_en         = 1'b1;
        wr_addr       = scan_ptr;
        wr_data.tries = rd_data.tries + 1'b1;
        wr_data.timer = cfg.timeout;
        scan_step     = 1'b1;
        emit          = 1'b1;
        e_kind        = KIND_RESENT;
        e_seq         = to_seq(scan_ptr);
        e_att         = rd_data.tries + 1'b1;
      end
      OP_SCAN_ABORT: begin
        aborted_next = 1'b1;
        emit         = 1'b1;
        e_kind       = KIND_GIVE_UP;
        e_seq        = to_seq(scan_ptr);
        e_att        = rd_data.tries;
      end
      OP_FINISH: begin
        finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // slot state memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_new  <= '0;
      base      <= '0;
      nts       <= '0;
      pending   <= '0;
      aborted   <= 1'b0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      next_new <= next_new_next;
      base     <= base_next;
      nts      <= nts_next;
      pending  <= pending_next;
      aborted  <= aborted_next;
      if (emit) begin
        held_v <= 1'b1;
      end else if (finish) begin
        held_v <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      ack_slot <= slot_of(ack_seq);
      scan_ptr <= base;
      scan_rem <= sent_span;
    end else if (scan_step) begin
      scan_ptr <= inc(scan_ptr);
      scan_rem <= scan_rem - 1'b1;
    end
    if (emit) begin
      held_kind  <= e_kind;
      held_seq   <= e_seq;
      held_att   <= e_att;
      held_outst <= pending_next;
    end
    // the held beat goes out only once it is known whether it ends the item
    if (load_out) begin
      out_last <= finish;
      if (held_v) begin
        out_kind        <= held_kind;
        out_seq         <= held_seq;
        out_attempt     <= held_att;
        out_outstanding <= held_outst;
      end else begin
        out_kind        <= KIND_IDLE;
        out_seq         <= '0;
        out_attempt     <= '0;
        out_outstanding <= pending;
      end
    end
  end

endmodule

/* rtl/core/srsw_ctrl.sv */
`timescale 1ns / 1ps

module srsw_ctrl import srsw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  input  dp_status_t       status,
  output dp_op_t           op
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN,
    ST_ACK_RD,
    ST_ACK_CHK,
    ST_SLIDE_RD,
    ST_SLIDE_CHK,
    ST_SEND,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIN
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op = OP_LATCH;
          if (status.aborted) begin
            state_next = ST_FIN;
          end else begin
            unique case (in_command)
              CMD_GENERATE: state_next = ST_GEN;
              CMD_ACK:      state_next = ST_ACK_RD;
              CMD_TICK:     state_next = ST_SCAN_RD;
              default:      state_next = ST_FIN;
            endcase
          end
        end
      end
      ST_GEN: begin
        if (status.emit_ok) begin
          if (status.full) begin
            op         = OP_GEN_FULL;
            state_next = ST_FIN;
          end else begin
            op         = OP_GEN_ADMIT;
            state_next = ST_SEND;
          end
        end
      end
      ST_ACK_RD: begin
        op         = OP_ACK_READ;
        state_next = ST_ACK_CHK;
      end
      ST_ACK_CHK: begin
        if (status.emit_ok) begin
          if (status.ack_ok) begin
            op         = OP_ACK_TAKE;
            state_next = ST_SLIDE_RD;
          end else begin
            op         = OP_ACK_IGNORE;
            state_next = ST_FIN;
          end
        end
      end
      ST_SLIDE_RD: begin
        if (status.slide_ok) begin
          op         = OP_SLIDE_READ;
          state_next = ST_SLIDE_CHK;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_SLIDE_CHK: begin
        if (status.rd_mark) begin
          op         = OP_SLIDE_CLEAR;
          state_next = ST_SLIDE_RD;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!status.send_ok) begin
          state_next = ST_FIN;
        end else if (status.emit_ok) begin
          op = OP_SEND;
        end
      end
      ST_SCAN_RD: begin
        if (status.scan_done) begin
          state_next = ST_FIN;
        end else begin
          op         = OP_SCAN_READ;
          state_next = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (status.rd_mark) begin
          op         = OP_SCAN_SKIP;
          state_next = ST_SCAN_RD;
        end else if (status.timer_gt1) begin
          op         = OP_SCAN_DEC;
          state_next = ST_SCAN_RD;
        end else if (status.emit_ok) begin
          if (status.at_limit) begin
            op         = OP_SCAN_ABORT;
            state_next = ST_FIN;
          end else begin
            op         = OP_SCAN_RESEND;
            state_next = ST_SCAN_RD;
          end
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          op         = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      in_ready <= 1'b1;
    end else begin
      state    <= state_next;
      in_ready <= (state_next == ST_IDLE);
    end
  end

endmodule

/* rtl/core/selective_repeat_sender_window.sv */
`timescale 1ns / 1ps

// Selective-repeat ARQ sender window. Each input beat carries a command in
// s_axis_tuser (generate, ack, tick; code 3 is a no-op) and, for acks, the
// acknowledged sequence number in s_axis_tdata. The block answers every input
// beat with one or more result beats on the m_axis side; the final one of an
// item has tlast set. Items are handled one at a time. Per-slot state (ack mark,
// try count, countdown timer) sits in a memory with one write port and one
// registered read port. A generate reports a full buffer or admits the packet
// and then sends while the window allows; an ack reads its slot and is either
// ignored or taken, and a taken ack reads the base slot and slides the base
// over acked slots before it sends; a tick reads each sent slot (at most the
// window, 8) and counts it down, resends it or gives up. Every item also passes
// through an idle state that accepts it and a closing state (an idle answer
// needs only these two). The longest item is an ack that slides the base over a
// full window of 8 and then sends 8, plus any output stalls. The slot memory
// needs no clearing after reset: a slot is cleared when it is admitted, and
// nothing relies on a slot's contents before that. Config writes are taken
// at any time but are only meant to happen while no item is in flight.
module selective_repeat_sender_window import srsw_pkg::*; #(
  parameter int SEQ_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // input item
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [3:0] ack_seq, [7:4] zero
  input  logic [CMD_W-1:0]     s_axis_tuser,   // [1:0] command
  // result item
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [3:0] seq, [7:4] attempt,
                                               // [12:8] outstanding, [15:13] zero
  output logic [KIND_W-1:0]    m_axis_tuser,   // [2:0] kind
  output logic                 m_axis_tlast,
  // config writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  // Clamp limits that follow from the sequence space size.
  localparam int WCAP = (SEQ_COUNT / 2 < 8) ? SEQ_COUNT / 2 : 8;
  localparam int BCAP = (SEQ_COUNT < 16) ? SEQ_COUNT : 16;

  logic [WIN_W-1:0]   win_size;
  logic [PEND_W-1:0]  buffer_limit;
  logic [TIMER_W-1:0] timeout_ticks;
  logic [RETRY_W-1:0] retry_limit;

  cfg_eff_t   cfg_eff;
  dp_op_t     op;
  dp_status_t status;
  kind_t      out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [ATT_W-1:0]  out_attempt;
  logic [PEND_W-1:0] out_outstanding;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size      <= WIN_W'(4);
      buffer_limit  <= PEND_W'(8);
      timeout_ticks <= TIMER_W'(300);
      retry_limit   <= RETRY_W'(9);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_SIZE:   win_size      <= cfg_data[WIN_W-1:0];
        REG_BUFFER_LIMIT:  buffer_limit  <= cfg_data[PEND_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data[TIMER_W-1:0];
        REG_RETRY_LIMIT:   retry_limit   <= cfg_data[RETRY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Effective settings: window 0 acts as 1 and saturates at WCAP, buffer
  // saturates at BCAP, a zero timeout acts as one tick.
  always_comb begin
    cfg_eff.window = (win_size == '0) ? WIN_W'(1) : win_size;
    if (cfg_eff.window > WIN_W'(WCAP)) begin
      cfg_eff.window = WIN_W'(WCAP);
    end
    cfg_eff.buffer  = (buffer_limit > PEND_W'(BCAP)) ? PEND_W'(BCAP) : buffer_limit;
    cfg_eff.timeout = (timeout_ticks == '0) ? TIMER_W'(1) : timeout_ticks;
    cfg_eff.retry   = retry_limit;
  end

  srsw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .status     (status),
    .op         (op)
  );

  srsw_datapath #(
    .SEQ_COUNT (SEQ_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .cfg             (cfg_eff),
    .ack_seq         (s_axis_tdata[SEQ_W-1:0]),
    .status          (status),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_kind        (out_kind),
    .out_seq         (out_seq),
    .out_attempt     (out_attempt),
    .out_outstanding (out_outstanding),
    .out_last        (m_axis_tlast)
  );

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {3'b000, out_outstanding, out_attempt, out_seq};

endmodule
